// ----- hw/rtl/cfv_pkg.sv -----
// shared types and constants of the command frame validator
// no dependencies; the top level, front end and back end refer to this package by scoped name
`default_nettype none

package cfv_pkg;

	// default sizes, used as the defaults of the top level parameters
	localparam int MAX_MESSAGE_DEF   = 64;
	localparam int TABLE_ENTRIES_DEF = 75;
	localparam int MID_DEPTH_DEF     = 4;
	localparam int OUT_DEPTH_DEF     = 4;

	// command code range and error marker
	localparam logic [7:0] CODE_LOW   = 8'd48;
	localparam logic [7:0] CODE_HIGH  = 8'd122;
	localparam logic [7:0] ERROR_CODE = 8'd33;

	// register reset values
	localparam logic [7:0]  END_RESET     = 8'd59;
	localparam logic [7:0]  DELIM_RESET   = 8'd44;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_REG  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_END     = 2'd0,
		CFG_DELIM   = 2'd1,
		CFG_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_DISPATCH    = 3'd0,
		ST_TIMEOUT     = 3'd1,
		ST_INVALID     = 3'd2,
		ST_UNREG       = 3'd3,
		ST_WRONG_COUNT = 3'd4
	} status_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		REQ_REG   = 2'd0,
		REQ_JUDGE = 2'd1,
		REQ_FAIL  = 2'd2
	} req_kind_t;

	typedef struct packed {
		req_kind_t  kind;
		status_t    fail_status;
		logic [7:0] code;
		logic [7:0] count;
		logic       enable;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] code;
		logic [7:0] count;
	} result_t;

	// front side push towards the request queue
	typedef struct packed {
		logic push;
		req_t req;
	} front_push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/command_frame_validator_top.sv -----
// top level of the command frame validator: front end, request queue,
// back end and result queue; uses cfv_pkg, cfv_fifo, cfv_front, cfv_back
//
//  channel   handshake             payload
//  input     push / full           operation, data_byte, arg_count, entry_enable
//  result    empty / pop           status, command_code, value_count
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one input beat per cycle while full is low; the result for an end byte or
// timing-out tick passes through the request queue, the table read and the
// result queue before it shows on the result ports. reset clears frame state,
// queues and the table's written marks at once, so beats are taken from the
// first cycle after reset. full rises when the request queue fills, which
// happens only while the back end holds judged or failed requests for lack of
// room in the result queue. config writes are always ready.
`default_nettype none

module command_frame_validator_top #(
	parameter int MAX_MESSAGE   = cfv_pkg::MAX_MESSAGE_DEF,
	parameter int TABLE_ENTRIES = cfv_pkg::TABLE_ENTRIES_DEF,
	parameter int MID_DEPTH     = cfv_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH     = cfv_pkg::OUT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  arg_count,
	input  wire logic        entry_enable,
	output logic             empty,
	input  wire logic        pop,
	output logic      [2:0]  status,
	output logic      [7:0]  command_code,
	output logic      [7:0]  value_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int RW  = $bits(cfv_pkg::req_t);
	localparam int SW  = $bits(cfv_pkg::result_t);
	localparam int MCW = $clog2(MID_DEPTH + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	cfv_pkg::front_push_t fp;
	cfv_pkg::req_t        head;
	cfv_pkg::result_t     res;
	cfv_pkg::result_t     out_item;
	logic                 mid_full;
	logic                 mid_empty;
	logic [MCW-1:0]       mid_count;
	logic                 mid_pop;
	logic                 res_valid;
	logic                 out_full;
	logic [OCW-1:0]       out_count;
	logic                 accept;

	assign full      = mid_full;
	assign accept    = push && !mid_full;
	assign cfg_ready = 1'b1;

	// front end
	cfv_front #(
		.MAX_MESSAGE  (MAX_MESSAGE),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (operation),
		.data_byte   (data_byte),
		.arg_count   (arg_count),
		.entry_enable(entry_enable),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fp          (fp)
	);

	// request queue between front and back
	cfv_fifo #(
		.WIDTH(RW),
		.DEPTH(MID_DEPTH)
	) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fp.push),
		.wdata (fp.req),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (head),
		.empty (mid_empty),
		.count (mid_count)
	);

	// back end
	cfv_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.OUT_DEPTH    (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_empty(mid_empty),
		.req      (head),
		.req_pop  (mid_pop),
		.out_count(out_count),
		.res_valid(res_valid),
		.res      (res)
	);

	// result queue
	cfv_fifo #(
		.WIDTH(SW),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_item),
		.empty (empty),
		.count (out_count)
	);

	assign status       = out_item.status;
	assign command_code = out_item.code;
	assign value_count  = out_item.count;

	// checks

	// the back end only produces a result when the result queue has room
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result beat dropped: result queue full");

	// a full request queue is never pushed
	assert property (@(posedge clk) disable iff (!arst_n)
		fp.push |-> !mid_full)
		else $error("request beat pushed into full queue");

	// request queue count never passes its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		mid_count <= MCW'(MID_DEPTH))
		else $error("request queue count out of range");

	// errors carry the error marker and a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (out_item.status != cfv_pkg::ST_DISPATCH))
			|-> (command_code == cfv_pkg::ERROR_CODE) && (value_count == 8'd0))
		else $error("error result with stray payload");

endmodule

`default_nettype wire

// ----- hw/rtl/cfv_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module cfv_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 75,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfv_fifo.sv -----
// small register queue with count, used between front and back and at the output
// no dependencies
`default_nettype none

module cfv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic      [CW-1:0]    count
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfv_front.sv -----
// front end: takes input beats, keeps the frame counters and config registers,
// and classifies each beat into a request for the back end; uses cfv_pkg
`default_nettype none

module cfv_front #(
	parameter int MAX_MESSAGE   = cfv_pkg::MAX_MESSAGE_DEF,
	parameter int TABLE_ENTRIES = cfv_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        operation,
	input  wire logic [7:0]        data_byte,
	input  wire logic [7:0]        arg_count,
	input  wire logic              entry_enable,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	output cfv_pkg::front_push_t   fp
);

	logic [7:0]  end_byte_q;
	logic [7:0]  delim_byte_q;
	logic [31:0] timeout_q;

	logic        active_q;
	logic [31:0] elapsed_q;
	logic [7:0]  bytes_q;
	logic [7:0]  delims_q;
	logic [7:0]  first_q;

	logic [7:0]  base_bytes;
	logic [7:0]  base_delims;
	logic [7:0]  cmd;
	logic        room;
	logic [7:0]  bytes_n;
	logic [7:0]  delims_n;
	logic [7:0]  values;
	logic [31:0] elapsed_n;
	logic        timed_out;
	logic        is_end;
	logic [7:0]  cmd_off;
	logic [7:0]  reg_off;
	logic        reg_in_table;

	// counters as they stand once this byte is taken
	always_comb begin
		base_bytes  = active_q ? bytes_q : 8'd0;
		base_delims = active_q ? delims_q : 8'd0;
		cmd         = active_q ? first_q : data_byte;
		room        = (base_bytes < 8'(MAX_MESSAGE));
		bytes_n     = room ? base_bytes + 8'd1 : base_bytes;
		delims_n    = base_delims;
		if (room && (data_byte == delim_byte_q) && (base_delims != 8'hFF)) begin
			delims_n = base_delims + 8'd1;
		end
		if (delims_n != 8'd0) begin
			values = (delims_n == 8'hFF) ? 8'hFF : delims_n + 8'd1;
		end else begin
			values = (bytes_n > 8'd2) ? 8'd1 : 8'd0;
		end
		is_end = (data_byte == end_byte_q);
	end

	// saturating tick count and timeout compare
	always_comb begin
		elapsed_n = (elapsed_q != 32'hFFFF_FFFF) ? elapsed_q + 32'd1 : elapsed_q;
		timed_out = (elapsed_n > timeout_q);
	end

	// table offsets
	assign cmd_off      = cmd - cfv_pkg::CODE_LOW;
	assign reg_off      = data_byte - cfv_pkg::CODE_LOW;
	assign reg_in_table = (data_byte >= cfv_pkg::CODE_LOW) && (reg_off < 8'(TABLE_ENTRIES));

	// classify the beat into a request
	always_comb begin
		fp.push             = 1'b0;
		fp.req.kind         = cfv_pkg::REQ_FAIL;
		fp.req.fail_status  = cfv_pkg::ST_TIMEOUT;
		fp.req.code         = data_byte;
		fp.req.count        = arg_count;
		fp.req.enable       = entry_enable;
		case (cfv_pkg::op_t'(operation))
			cfv_pkg::OP_BYTE: begin
				if (is_end) begin
					fp.push      = accept;
					fp.req.code  = cmd;
					fp.req.count = values;
					if ((cmd < cfv_pkg::CODE_LOW) || (cmd > cfv_pkg::CODE_HIGH)) begin
						fp.req.kind        = cfv_pkg::REQ_FAIL;
						fp.req.fail_status = cfv_pkg::ST_INVALID;
					end else if (cmd_off >= 8'(TABLE_ENTRIES)) begin
						fp.req.kind        = cfv_pkg::REQ_FAIL;
						fp.req.fail_status = cfv_pkg::ST_UNREG;
					end else begin
						fp.req.kind = cfv_pkg::REQ_JUDGE;
					end
				end
			end
			cfv_pkg::OP_TICK: begin
				fp.push            = accept && active_q && timed_out;
				fp.req.kind        = cfv_pkg::REQ_FAIL;
				fp.req.fail_status = cfv_pkg::ST_TIMEOUT;
			end
			cfv_pkg::OP_REG: begin
				fp.push     = accept && reg_in_table;
				fp.req.kind = cfv_pkg::REQ_REG;
			end
			default: begin
				fp.push = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q   <= cfv_pkg::END_RESET;
			delim_byte_q <= cfv_pkg::DELIM_RESET;
			timeout_q    <= cfv_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfv_pkg::cfg_idx_t'(cfg_index))
				cfv_pkg::CFG_END:     end_byte_q   <= cfg_data[7:0];
				cfv_pkg::CFG_DELIM:   delim_byte_q <= cfg_data[7:0];
				cfv_pkg::CFG_TIMEOUT: timeout_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
			bytes_q   <= '0;
			delims_q  <= '0;
			first_q   <= '0;
		end else if (accept) begin
			case (cfv_pkg::op_t'(operation))
				cfv_pkg::OP_BYTE: begin
					if (is_end) begin
						active_q  <= 1'b0;
						elapsed_q <= '0;
						bytes_q   <= '0;
						delims_q  <= '0;
						first_q   <= '0;
					end else begin
						active_q  <= 1'b1;
						elapsed_q <= active_q ? elapsed_q : 32'd0;
						bytes_q   <= bytes_n;
						delims_q  <= delims_n;
						first_q   <= cmd;
					end
				end
				cfv_pkg::OP_TICK: begin
					if (active_q) begin
						if (timed_out) begin
							active_q  <= 1'b0;
							elapsed_q <= '0;
							bytes_q   <= '0;
							delims_q  <= '0;
							first_q   <= '0;
						end else begin
							elapsed_q <= elapsed_n;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfv_back.sv -----
// back end: owns the command table, applies registrations in order, judges
// closed frames against it and passes failed frames on; uses cfv_pkg and cfv_ram
`default_nettype none

module cfv_back #(
	parameter int TABLE_ENTRIES = cfv_pkg::TABLE_ENTRIES_DEF,
	parameter int OUT_DEPTH     = cfv_pkg::OUT_DEPTH_DEF,
	localparam int IW           = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int OCW          = $clog2(OUT_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_empty,
	input  wire cfv_pkg::req_t    req,
	output logic                  req_pop,
	input  wire logic [OCW-1:0]   out_count,
	output logic                  res_valid,
	output cfv_pkg::result_t      res
);

	logic [TABLE_ENTRIES-1:0] written_q;
	logic                     valid_s1;
	cfv_pkg::req_t            req_s1;
	logic                     written_s1;
	logic [8:0]               entry_s1;
	logic [7:0]               off;
	logic [IW-1:0]            idx;
	logic                     is_reg;
	logic                     room;
	logic                     take;

	assign off    = req.code - cfv_pkg::CODE_LOW;
	assign idx    = off[IW-1:0];
	assign is_reg = (req.kind == cfv_pkg::REQ_REG);

	// a judged or failed beat needs a free output slot, counting the one in flight
	assign room    = (({1'b0, out_count} + (OCW + 1)'(valid_s1)) < (OCW + 1)'(OUT_DEPTH));
	assign take    = !req_empty && (is_reg || room);
	assign req_pop = take;

	// command table: bit 8 registered, bits 7..0 expected count
	cfv_ram #(
		.WIDTH(9),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (take && is_reg),
		.waddr(idx),
		.wdata({req.enable, req.count}),
		.re   (take && (req.kind == cfv_pkg::REQ_JUDGE)),
		.raddr(idx),
		.rdata(entry_s1)
	);

	// per-entry written marks, an unwritten entry reads as unregistered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (take && is_reg) begin
			written_q[idx] <= 1'b1;
		end
	end

	// lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take && !is_reg;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_reg) begin
			req_s1     <= req;
			written_s1 <= written_q[idx];
		end
	end

	// final verdict
	always_comb begin
		res_valid  = valid_s1;
		res.status = cfv_pkg::ST_DISPATCH;
		res.code   = cfv_pkg::ERROR_CODE;
		res.count  = 8'd0;
		case (req_s1.kind)
			cfv_pkg::REQ_JUDGE: begin
				if (!written_s1 || !entry_s1[8]) begin
					res.status = cfv_pkg::ST_UNREG;
				end else if (entry_s1[7:0] != req_s1.count) begin
					res.status = cfv_pkg::ST_WRONG_COUNT;
				end else begin
					res.status = cfv_pkg::ST_DISPATCH;
					res.code   = req_s1.code;
					res.count  = req_s1.count;
				end
			end
			default: begin
				res.status = req_s1.fail_status;
			end
		endcase
	end

endmodule

`default_nettype wire
